/* rtl/core/epid_pkg.sv */
// Package: payload types, codes and decode functions for the ext-prefixed decoder.
`default_nettype none
package epid_pkg;

  typedef struct packed {
    logic [15:0] halfword;
    logic [31:0] halfword_address;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  insn_code;
    logic [1:0]  ext_used;
    logic [3:0]  reg_d;
    logic [3:0]  reg_s;
    logic [31:0] imm_value;
    logic [2:0]  byte_length;
  } out_word_t;

  localparam logic [2:0] ClsExt = 3'd6;
  localparam logic [6:0] CodeUndef = 7'd0;
  localparam logic [6:0] CodeInt = 7'd10;
  localparam logic [6:0] CodeBtst = 7'd109;
  localparam logic [6:0] CodeBnot = 7'd112;
  localparam logic [6:0] CodeLdcA = 7'd117;
  localparam logic [6:0] CodeLdcB = 7'd118;
  localparam logic [6:0] CodeDoc = 7'd121;
  localparam logic [6:0] CodePsrset = 7'd122;
  localparam logic [6:0] CodePsrclr = 7'd123;
  localparam logic [6:0] CodeExt = 7'd124;

  function automatic logic [6:0] k0(input logic [4:0] i);
    case (i)
      5'd0: k0 = 7'd1;   5'd1: k0 = 7'd2;   5'd2: k0 = 7'd3;   5'd8: k0 = 7'd4;
      5'd9: k0 = 7'd5;   5'd11: k0 = 7'd6;  5'd15: k0 = 7'd7;  5'd16: k0 = 7'd8;
      5'd17: k0 = 7'd9;  5'd18: k0 = 7'd10; 5'd19: k0 = 7'd11; 5'd24: k0 = 7'd12;
      5'd25: k0 = 7'd13; 5'd26: k0 = 7'd14; 5'd28: k0 = 7'd15; 5'd29: k0 = 7'd16;
      5'd30: k0 = 7'd17;
      default: k0 = CodeUndef;
    endcase
  endfunction

  function automatic logic [6:0] k5(input logic [4:0] i);
    case (i)
      5'd0: k5 = 7'd103;  5'd1: k5 = 7'd104;  5'd2: k5 = 7'd105;  5'd4: k5 = 7'd106;
      5'd5: k5 = 7'd107;  5'd6: k5 = 7'd108;  5'd8: k5 = 7'd109;  5'd9: k5 = 7'd113;
      5'd10: k5 = 7'd114; 5'd12: k5 = 7'd110; 5'd13: k5 = 7'd115; 5'd14: k5 = 7'd116;
      5'd16: k5 = 7'd111; 5'd17: k5 = 7'd117; 5'd20: k5 = 7'd112; 5'd21: k5 = 7'd118;
      5'd24: k5 = 7'd119; 5'd28: k5 = 7'd120; 5'd31: k5 = 7'd121;
      default: k5 = CodeUndef;
    endcase
  endfunction

  function automatic logic [31:0] sx13(input logic [12:0] v);
    sx13 = {{19{v[12]}}, v};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ext_prefixed_instruction_decoder.sv */
// Top level: input register, prefix store, decode and result register.
// An accepted word passes the input register, then decode, then the result register.
// Throughput: one halfword per cycle while in_stall_o is low; ext prefixes produce no result word.
// The prefix state sits at the input register and is updated as each word enters.
// Reset: asynchronous, active low; clears valids and the prefix store.
`default_nettype none
module ext_prefixed_instruction_decoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire epid_pkg::in_word_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      epid_pkg::out_word_t out_data_o
);
  import epid_pkg::*;

  logic        s1_valid_q;
  logic [15:0] s1_hw_q;
  logic [31:0] s1_addr_q;
  logic [1:0]  s1_n_q;
  logic [12:0] s1_e0_q, s1_e1_q;
  logic [1:0]  cnt_q;
  logic [12:0] e0_q, e1_q;
  logic        out_valid_q;
  out_word_t   out_q, dec;
  logic        adv, take, is_pref;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;
  assign is_pref    = in_data_i.halfword[15:13] == ClsExt && cnt_q != 2'd2;

  epid_decode u_dec (
    .hw_i  (s1_hw_q),
    .addr_i(s1_addr_q),
    .n_i   (s1_n_q),
    .e0_i  (s1_e0_q),
    .e1_i  (s1_e1_q),
    .res_o (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      e0_q        <= '0;
      e1_q        <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) out_q <= dec;
      end
      if (adv || !s1_valid_q) s1_valid_q <= take && !is_pref;
      if (take) begin
        if (is_pref) begin
          if (cnt_q == 2'd0) e0_q <= in_data_i.halfword[12:0];
          else e1_q <= in_data_i.halfword[12:0];
          cnt_q <= cnt_q + 2'd1;
        end else begin
          s1_hw_q   <= in_data_i.halfword;
          s1_addr_q <= in_data_i.halfword_address;
          s1_n_q    <= cnt_q;
          s1_e0_q   <= e0_q;
          s1_e1_q   <= e1_q;
          cnt_q     <= '0;
          e0_q      <= '0;
          e1_q      <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("prefix count overflow");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.byte_length == {out_data_o.ext_used, 1'b0} + 3'd2)
    else $error("byte length mismatch");
  a_undef_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.insn_code == CodeUndef) |-> out_data_o.imm_value == 32'd0)
    else $error("undefined code with immediate");
  a_pref_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_pref) |=> cnt_q == 2'd0)
    else $error("prefix store not cleared");
`endif
endmodule
`default_nettype wire

/* rtl/core/epid_decode.sv */
// Combinational decode of one halfword with the held ext prefixes.
`default_nettype none
module epid_decode (
  input  wire logic [15:0]     hw_i,
  input  wire logic [31:0]     addr_i,
  input  wire logic [1:0]      n_i,
  input  wire logic [12:0]     e0_i,
  input  wire logic [12:0]     e1_i,
  output epid_pkg::out_word_t  res_o
);
  import epid_pkg::*;

  logic [2:0]  cls, op1;
  logic [1:0]  op2;
  logic [3:0]  o;
  logic [5:0]  imm6;
  logic [31:0] xi, imm, off;
  logic [6:0]  code;

  always_comb begin
    cls  = hw_i[15:13];
    op1  = hw_i[12:10];
    op2  = hw_i[9:8];
    o    = hw_i[12:9];
    imm6 = hw_i[9:4];
    xi   = (n_i == 2'd1) ? {19'd0, e0_i} : {6'd0, e0_i, e1_i};
    imm  = '0;
    code = CodeUndef;
    off  = '0;
    unique case (cls)
      3'd0: begin
        if (o <= 4'd3) begin
          if (hw_i[5:4] == 2'd0) begin
            code = k0({o[1:0], hw_i[8], hw_i[7:6]});
            if (code == CodeInt) imm = {30'd0, hw_i[1:0]};
          end else if (hw_i[5:4] == 2'd1 && o == 4'd0) begin
            case (hw_i[8:6])
              3'd0: code = 7'd18;
              3'd1: code = 7'd19;
              3'd2: code = 7'd20;
              3'd3: code = 7'd21;
              3'd7: code = 7'd22;
              default: code = CodeUndef;
            endcase
          end
        end else begin
          if (n_i == 2'd0) off = {{23{hw_i[7]}}, hw_i[7:0], 1'b0};
          else if (n_i == 2'd1) off = (sx13(e0_i) << 9) | {23'd0, hw_i[7:0], 1'b0};
          else off = {e0_i[12:3], e1_i, hw_i[7:0], 1'b0};
          imm  = addr_i + off;
          code = 7'd23 + {2'd0, o - 4'd4, 1'b0} + {6'd0, hw_i[8]};
        end
      end
      3'd1: begin
        if (op2 == 2'd3) begin
          if (op1 <= 3'd5) begin
            imm  = {27'd0, 1'b1, hw_i[7:4]};
            code = 7'd47 + {4'd0, op1};
          end
        end else begin
          if (n_i != 2'd0) imm = xi;
          if (op2 == 2'd2) code = 7'd53 + {4'd0, op1};
          else if (op2 == 2'd1 && n_i == 2'd0) code = 7'd69 + {4'd0, op1};
          else code = 7'd61 + {4'd0, op1};
        end
      end
      3'd2: begin
        if (n_i == 2'd0) imm = {26'd0, imm6};
        else if (n_i == 2'd1) imm = {13'd0, e0_i, imm6};
        else imm = {e0_i, e1_i, imm6};
        code = 7'd77 + {4'd0, op1};
      end
      3'd3: begin
        if (n_i == 2'd0) imm = (op1 <= 3'd1) ? {26'd0, imm6} : {{26{imm6[5]}}, imm6};
        else if (n_i == 2'd1)
          imm = (op1 <= 3'd1) ? {13'd0, e0_i, imm6} : {{13{e0_i[12]}}, e0_i, imm6};
        else imm = {e0_i, e1_i, imm6};
        code = 7'd85 + {4'd0, op1};
      end
      3'd4: begin
        if (op1 <= 3'd1) begin
          imm  = {22'd0, hw_i[9:0]};
          code = 7'd93 + {4'd0, op1};
        end else if (op2 == 2'd2 && op1 == 3'd4) code = 7'd95;
        else if (op2 == 2'd2 && op1 == 3'd6) code = 7'd96;
        else if (op2 == 2'd0) begin
          imm  = {28'd0, hw_i[7:4]};
          code = 7'd47 + {4'd0, op1 - 3'd2};
        end else code = 7'd97 + {4'd0, op1 - 3'd2};
      end
      3'd5: begin
        code = k5({op1, op2});
        if (code >= CodeBtst && code <= CodeBnot) begin
          if (n_i != 2'd0) imm = xi;
        end else if (code == CodeLdcA || code == CodeLdcB) begin
          imm = {28'd0, hw_i[7:4]};
        end else if (code == CodeDoc) begin
          if (hw_i[7:6] == 2'd0) imm = {26'd0, hw_i[5:0]};
          else begin
            imm  = {27'd0, hw_i[4:0]};
            code = (hw_i[7:6] == 2'd1) ? CodePsrset : CodePsrclr;
          end
        end
      end
      3'd6: begin
        imm  = {19'd0, hw_i[12:0]};
        code = CodeExt;
      end
      default: code = CodeUndef;
    endcase
    if (code == CodeUndef) imm = '0;
    res_o.insn_code   = code;
    res_o.ext_used    = n_i;
    res_o.reg_d       = hw_i[3:0];
    res_o.reg_s       = hw_i[7:4];
    res_o.imm_value   = imm;
    res_o.byte_length = {n_i, 1'b0} + 3'd2;
  end
endmodule
`default_nettype wire
